@@ hw/rtl/aes_cmac_mic_engine_core_assert.svh @@
// Assertion macros used by the checker file.
`ifndef AES_CMAC_MIC_ENGINE_CORE_ASSERT_SVH
`define AES_CMAC_MIC_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define CMAC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CMAC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/cmac_mic_pkg.sv @@
`timescale 1ns / 1ps
package cmac_mic_pkg;

  localparam logic [7:0] B0_TAG   = 8'h49;
  localparam logic [7:0] B0_FLAGS = 8'h0F;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [7:0] DBL_POLY = 8'h87;
  localparam logic [7:0] XT_POLY  = 8'h1B;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  localparam int AES_ROUNDS = 10;

  typedef struct packed {
    logic load;
    logic key_start;
    logic sub_load;
    logic byte_take;
    logic abs_start;
    logic abs_store;
    logic fin_start;
    logic out_load;
  } cmac_cmd_t;

  typedef struct packed {
    logic first;
    logic has_byte;
    logic last;
    logic total_full;
    logic fill_full;
    logic aes_done;
    logic out_free;
  } cmac_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] a);
    return SBOX[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? XT_POLY : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    unique case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // byte i of a block sits at bits 8i+7:8i
  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {sbox(rk[103:96]), sbox(rk[127:120]), sbox(rk[119:112]), sbox(rk[111:104]) ^ rc};
    w0 = rk[31:0] ^ t;
    w1 = rk[63:32] ^ w0;
    w2 = rk[95:64] ^ w1;
    w3 = rk[127:96] ^ w2;
    return {w3, w2, w1, w0};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
    logic [7:0] sb [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) sb[i] = sbox(s[8*i +: 8]);
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++)
        t[c*4 + w] = sb[((c + w) & 3) * 4 + w];
    for (int c = 0; c < 4; c++) begin
      a0  = t[c*4];
      a1  = t[c*4 + 1];
      a2  = t[c*4 + 2];
      a3  = t[c*4 + 3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (fin) begin
        r[32*c +: 32] = {a3, a2, a1, a0};
      end else begin
        r[32*c +: 32] = {a3 ^ all ^ xt(a3 ^ a0), a2 ^ all ^ xt(a2 ^ a3),
                         a1 ^ all ^ xt(a1 ^ a2), a0 ^ all ^ xt(a0 ^ a1)};
      end
    end
    return r;
  endfunction

  // CMAC doubling, byte 0 is the most significant
  function automatic logic [127:0] dbl(input logic [127:0] a);
    logic [127:0] r;
    for (int i = 0; i < 15; i++) r[8*i +: 8] = {a[8*i +: 7], a[8*(i+1) + 7]};
    r[127:120] = {a[126:120], 1'b0} ^ (a[7] ? DBL_POLY : 8'h00);
    return r;
  endfunction

endpackage

@@ hw/rtl/cmac_mic_aes.sv @@
`timescale 1ns / 1ps
module cmac_mic_aes (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] din,
  input  logic [127:0] key,
  output logic         done,
  output logic [127:0] dout
);
  import cmac_mic_pkg::*;

  logic         busy;
  logic [3:0]   rnd;
  logic [127:0] state;
  logic [127:0] rk;
  logic [127:0] rk_next;

  // key schedule runs forward alongside the rounds
  assign rk_next = key_next(rk, rcon(rnd));
  assign dout    = state;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd  <= 4'd1;
      end else if (busy) begin
        rnd <= rnd + 4'd1;
        if (rnd == 4'(AES_ROUNDS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      state <= din ^ key;
      rk    <= key;
    end else if (busy) begin
      state <= aes_round(state, rnd == 4'(AES_ROUNDS)) ^ rk_next;
      rk    <= rk_next;
    end
  end

endmodule

@@ hw/rtl/cmac_mic_ctrl.sv @@
`timescale 1ns / 1ps
module cmac_mic_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  cmac_mic_pkg::cmac_stat_t stat,
  output cmac_mic_pkg::cmac_cmd_t  cmd
);
  import cmac_mic_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HEAD  = 3'd1;
  localparam logic [2:0] S_KEY   = 3'd2;
  localparam logic [2:0] S_BYTE  = 3'd3;
  localparam logic [2:0] S_ABS   = 3'd4;
  localparam logic [2:0] S_FINGO = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // no transfer is taken while reset is held
  assign s_tready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.load   = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        if (stat.first) begin
          cmd.key_start = 1'b1;
          state_next    = S_KEY;
        end else begin
          state_next = S_BYTE;
        end
      end
      S_KEY: begin
        if (stat.aes_done) begin
          cmd.sub_load = 1'b1;
          state_next   = S_BYTE;
        end
      end
      S_BYTE: begin
        if (stat.has_byte && !stat.total_full && stat.fill_full) begin
          cmd.abs_start = 1'b1;
          state_next    = S_ABS;
        end else begin
          cmd.byte_take = 1'b1;
          state_next    = stat.last ? S_FINGO : S_IDLE;
        end
      end
      S_ABS: begin
        if (stat.aes_done) begin
          cmd.abs_store = 1'b1;
          state_next    = S_BYTE;
        end
      end
      S_FINGO: begin
        cmd.fin_start = 1'b1;
        state_next    = S_FIN;
      end
      S_FIN: begin
        if (stat.aes_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

@@ hw/rtl/cmac_mic_dp.sv @@
`timescale 1ns / 1ps
module cmac_mic_dp #(
  parameter int MAX_MESSAGE = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [63:0]             cfg_data,
  input  logic [2:0]              s_tuser,
  input  logic                    s_tlast,
  input  logic [87:0]             s_tdata,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [31:0]             m_tdata,
  output logic [1:0]              m_tuser,
  input  cmac_mic_pkg::cmac_cmd_t  cmd,
  output cmac_mic_pkg::cmac_stat_t stat
);
  import cmac_mic_pkg::*;

  logic [63:0]  key_low, key_high;
  logic [127:0] key_held;
  logic         it_first, it_has, it_last;
  logic [7:0]   it_byte;
  logic         verify_mode, length_error;
  logic [31:0]  held_expected;
  logic [127:0] block;
  logic [4:0]   fill;
  logic [8:0]   total;
  logic [127:0] chain, k1, k2;
  logic [127:0] fin_x, aes_din, aes_dout;
  logic         aes_start, aes_done;

  // item fields
  logic [8:0]  in_len;
  logic [15:0] in_pan;
  logic [7:0]  in_dest, in_src;
  logic [31:0] in_exp;
  assign in_len  = s_tdata[16:8];
  assign in_pan  = s_tdata[32:17];
  assign in_dest = s_tdata[40:33];
  assign in_src  = s_tdata[48:41];
  assign in_exp  = s_tdata[80:49];

  assign stat.first      = it_first;
  assign stat.has_byte   = it_has;
  assign stat.last       = it_last;
  assign stat.total_full = (total >= 9'(MAX_MESSAGE));
  assign stat.fill_full  = fill[4];
  assign stat.aes_done   = aes_done;
  assign stat.out_free   = !m_tvalid || m_tready;

  // last block: complete one takes K1, partial one is padded and takes K2
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (fill[4] || 5'(i) < fill) fin_x[8*i +: 8] = block[8*i +: 8];
      else if (5'(i) == fill)      fin_x[8*i +: 8] = PAD_BYTE;
      else                         fin_x[8*i +: 8] = 8'h00;
    end
    fin_x = fin_x ^ (fill[4] ? k1 : k2) ^ chain;
  end

  assign aes_start = cmd.key_start || cmd.abs_start || cmd.fin_start;

  always_comb begin
    priority if (cmd.abs_start) aes_din = chain ^ block;
    else if (cmd.fin_start)     aes_din = fin_x;
    else                        aes_din = '0;
  end

  cmac_mic_aes u_aes (
    .clk   (clk),
    .rst   (rst),
    .start (aes_start),
    .din   (aes_din),
    .key   (key_held),
    .done  (aes_done),
    .dout  (aes_dout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_KEY_LOW) key_low  <= cfg_data;
      else                          key_high <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_first <= s_tuser[1];
      it_has   <= s_tuser[2];
      it_last  <= s_tlast;
      it_byte  <= s_tdata[7:0];
    end
    if (cmd.load && s_tuser[1]) begin
      key_held <= {key_high, key_low};
      block    <= {B0_FLAGS, in_src, 24'h0, in_dest, 16'h0, in_pan[15:8], in_pan[7:0],
                   in_len[7:0], 32'h0, B0_TAG};
    end
    if (cmd.sub_load) begin
      k1 <= dbl(aes_dout);
      k2 <= dbl(dbl(aes_dout));
    end
    if (cmd.byte_take && it_has && !stat.total_full) block[8*fill[3:0] +: 8] <= it_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verify_mode   <= 1'b0;
      held_expected <= '0;
      length_error  <= 1'b0;
      chain         <= '0;
      fill          <= '0;
      total         <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      if (cmd.load && s_tuser[1]) begin
        verify_mode   <= s_tuser[0];
        held_expected <= in_exp;
        length_error  <= (in_len > 9'(MAX_MESSAGE));
        chain         <= '0;
        fill          <= 5'd16;
        total         <= '0;
      end
      if (cmd.abs_store) begin
        chain <= aes_dout;
        fill  <= '0;
      end
      if (cmd.byte_take && it_has) begin
        if (stat.total_full) begin
          length_error <= 1'b1;
        end else begin
          fill  <= fill + 5'd1;
          total <= total + 9'd1;
        end
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
        chain    <= '0;
        fill     <= '0;
        total    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (length_error) begin
        m_tdata <= '0;
        m_tuser <= ST_TOO_LONG;
      end else begin
        m_tdata <= aes_dout[31:0];
        m_tuser <= (verify_mode && aes_dout[31:0] != held_expected) ? ST_MISMATCH : ST_OK;
      end
    end
  end

endmodule

@@ hw/rtl/aes_cmac_mic_engine_core.sv @@
// A plain item passes through the header and byte states before the next transfer is taken;
// a first item adds the subkey AES, each absorbed block adds an AES encryption, and a last item adds
// the final AES, at the end of which its result is valid (plus any wait for the output register).
// Items are taken one at a time; the iterative AES unit (one round per cycle) limits the rate.
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous): clears keys, control state and the chain; no clearing pass.
`timescale 1ns / 1ps
module aes_cmac_mic_engine_core #(
  parameter int MAX_MESSAGE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // data_byte, msg_len, pan_id, dest_addr, src_addr, expected_mic, zero fill
  input  logic [87:0] s_tdata,
  // command, first, has_byte
  input  logic [2:0]  s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // mic
  output logic [31:0] m_tdata,
  // status
  output logic [1:0]  m_tuser
);
  import cmac_mic_pkg::*;

  cmac_cmd_t  cmd;
  cmac_stat_t stat;

  cmac_mic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cmac_mic_dp #(
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ hw/rtl/cmac_mic_checker.sv @@
`timescale 1ns / 1ps
`include "aes_cmac_mic_engine_core_assert.svh"
module cmac_mic_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import cmac_mic_pkg::*;

  `CMAC_ASSERT_NOW(a_status_code, clk, rst, m_tvalid, m_tuser != 2'd3)
  `CMAC_ASSERT_NOW(a_too_long_zero, clk, rst, m_tvalid && m_tuser == ST_TOO_LONG, m_tdata == 32'd0)
  `CMAC_ASSERT_NEXT(a_busy_after_take, clk, rst, s_tvalid && s_tready, !s_tready)
  `CMAC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind aes_cmac_mic_engine_core cmac_mic_checker u_chk (.*);
